// ===== rtl/frl_pkg.sv =====
// ----------------------------------------------------------------------------
// Fresnel reflectance package
// Shared constants and the side data that travels with each item.
// ----------------------------------------------------------------------------
package frl_pkg;

	localparam logic [15:0] ONE_Q15 = 16'd32768;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	// Front stages, cosine divider, square root, divider for the ratios, back stages.
	localparam int LATENCY = 9 + 31 + 16 + 17;

	typedef struct packed {
		logic [15:0] c;
		logic [15:0] n1;
		logic [15:0] n2;
		logic        zero_f;
		logic        one_f;
	} side_t;

endpackage

// ===== rtl/fresnel_reflectance_core.sv =====
// ----------------------------------------------------------------------------
// Fresnel reflectance core
// Unpolarized reflectance of a dielectric interface, Q1.15 result.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Fields
// command   in         start, busy          cos_incident, index_incident,
//                                           index_transmit
// result    out        done (one cycle)     reflectance
//
// One item is taken in every cycle; busy never rises.
// Each result passes through the 31 stages of the cosine divider, the 16
// stages of the square root and the 17 stages of the ratio dividers plus
// nine arithmetic stages.
// Reset clears only the valid bits; items in flight are dropped.
// The receiver cannot stall, so nothing holds the pipeline.
// ----------------------------------------------------------------------------
module fresnel_reflectance_core
	import frl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] cos_incident,
	input  logic [15:0] index_incident,
	input  logic [15:0] index_transmit,
	output logic        done,
	output logic [15:0] reflectance
);

	assign busy = 1'b0;

	// Stage 1: clamp the cosine.
	logic        valid_s1;
	logic [15:0] c_s1, n1_s1, n2_s1;

	always_ff @(posedge clk) begin
		c_s1  <= (cos_incident > ONE_Q15) ? ONE_Q15 : cos_incident;
		n1_s1 <= index_incident;
		n2_s1 <= index_transmit;
	end

	// Stage 2: squares.
	logic        valid_s2;
	logic [30:0] om_s2;
	logic [31:0] n1sq_s2, n2sq_s2;
	side_t       side_s2;
	logic [31:0] csq;

	assign csq = 32'(c_s1) * 32'(c_s1);

	always_ff @(posedge clk) begin
		om_s2          <= ONE_Q30 - csq[30:0];
		n1sq_s2        <= 32'(n1_s1) * 32'(n1_s1);
		n2sq_s2        <= 32'(n2_s1) * 32'(n2_s1);
		side_s2.c      <= c_s1;
		side_s2.n1     <= n1_s1;
		side_s2.n2     <= n2_s1;
		side_s2.zero_f <= (n1_s1 == n2_s1);
		side_s2.one_f  <= (n2_s1 == '0);
	end

	// Stage 3: partial products of n1^2 * (1 - c^2).
	logic        valid_s3;
	logic [47:0] pp_lo_s3;
	logic [46:0] pp_hi_s3;
	logic [31:0] n2sq_s3;
	side_t       side_s3;

	always_ff @(posedge clk) begin
		pp_lo_s3 <= 48'(n1sq_s2) * 48'(om_s2[15:0]);
		pp_hi_s3 <= 47'(n1sq_s2) * 47'(om_s2[30:16]);
		n2sq_s3  <= n2sq_s2;
		side_s3  <= side_s2;
	end

	// Stage 4: combine the partial products.
	logic        valid_s4;
	logic [62:0] lhs_s4;
	logic [31:0] n2sq_s4;
	side_t       side_s4;

	always_ff @(posedge clk) begin
		lhs_s4  <= 63'(pp_lo_s3) + {pp_hi_s3, 16'd0};
		n2sq_s4 <= n2sq_s3;
		side_s4 <= side_s3;
	end

	// Stage 5: total internal reflection shows as a borrow.
	logic        valid_s5;
	logic [61:0] num_s5;
	logic [31:0] n2sq_s5;
	side_t       side_s5;
	logic [63:0] tir_diff;
	side_t       tir_side;

	assign tir_diff = {2'b00, n2sq_s4, 30'd0} - {1'b0, lhs_s4};

	always_comb begin
		tir_side       = side_s4;
		tir_side.one_f = side_s4.one_f | tir_diff[63];
	end

	always_ff @(posedge clk) begin
		num_s5  <= tir_diff[61:0];
		n2sq_s5 <= n2sq_s4;
		side_s5 <= tir_side;
	end

	// Squared cosine of the transmitted angle.
	logic        dv1_valid;
	logic [30:0] dv1_quo;
	side_t       dv1_side;

	frl_div #(.NW(62), .DW(32), .QW(31), .TW($bits(side_t))) u_div_cos (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_s5),
		.num_i   (num_s5),
		.den_i   (n2sq_s5),
		.tag_i   (side_s5),
		.valid_o (dv1_valid),
		.quo_o   (dv1_quo),
		.tag_o   (dv1_side)
	);

	// Square root, two radicand bits per stage.
	logic        sq_valid_s [1:16];
	logic [18:0] sq_rem_s   [1:16];
	logic [15:0] sq_root_s  [1:16];
	logic [31:0] sq_v_s     [1:16];
	side_t       sq_side_s  [1:16];

	for (genvar k = 0; k < 16; k++) begin : g_sqrt
		localparam int Pos = 15 - k;
		logic        cur_valid;
		logic [18:0] cur_rem;
		logic [15:0] cur_root;
		logic [31:0] cur_v;
		side_t       cur_side;
		logic [18:0] shifted;
		logic [18:0] trial;
		logic        ge;

		if (k == 0) begin : g_first
			assign cur_valid = dv1_valid;
			assign cur_rem   = '0;
			assign cur_root  = '0;
			assign cur_v     = {1'b0, dv1_quo};
			assign cur_side  = dv1_side;
		end else begin : g_next
			assign cur_valid = sq_valid_s[k];
			assign cur_rem   = sq_rem_s[k];
			assign cur_root  = sq_root_s[k];
			assign cur_v     = sq_v_s[k];
			assign cur_side  = sq_side_s[k];
		end

		assign shifted = {cur_rem[16:0], cur_v[2*Pos+1 -: 2]};
		assign trial   = {1'b0, cur_root, 2'b01};
		assign ge      = (shifted >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_valid_s[k+1] <= 1'b0;
			end else begin
				sq_valid_s[k+1] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			sq_rem_s[k+1]  <= ge ? (shifted - trial) : shifted;
			sq_root_s[k+1] <= {cur_root[14:0], ge};
			sq_v_s[k+1]    <= cur_v;
			sq_side_s[k+1] <= cur_side;
		end
	end

	// Stage 6: the four products n*cos.
	logic        valid_s6;
	logic [31:0] a_s6, b_s6, p_s6, q_s6;
	side_t       side_s6;
	logic [15:0] ct;
	side_t       sq_side;

	assign ct      = sq_root_s[16];
	assign sq_side = sq_side_s[16];

	always_ff @(posedge clk) begin
		a_s6    <= 32'(sq_side.n1) * 32'(sq_side.c);
		b_s6    <= 32'(sq_side.n2) * 32'(ct);
		p_s6    <= 32'(sq_side.n1) * 32'(ct);
		q_s6    <= 32'(sq_side.n2) * 32'(sq_side.c);
		side_s6 <= sq_side;
	end

	// Stage 7: sums and absolute differences.
	logic        valid_s7;
	logic [32:0] sab_s7, spq_s7;
	logic [31:0] dab_s7, dpq_s7;
	side_t       side_s7;
	logic [32:0] sab, spq;
	side_t       graze_side;

	assign sab = 33'(a_s6) + 33'(b_s6);
	assign spq = 33'(p_s6) + 33'(q_s6);

	// A zero denominator means grazing incidence or a zero index.
	always_comb begin
		graze_side       = side_s6;
		graze_side.one_f = side_s6.one_f | (sab == '0) | (spq == '0);
	end

	always_ff @(posedge clk) begin
		sab_s7  <= sab;
		spq_s7  <= spq;
		dab_s7  <= (a_s6 > b_s6) ? (a_s6 - b_s6) : (b_s6 - a_s6);
		dpq_s7  <= (p_s6 > q_s6) ? (p_s6 - q_s6) : (q_s6 - p_s6);
		side_s7 <= graze_side;
	end

	// Ratio dividers, both in lockstep.
	logic        dv2_valid;
	logic [16:0] r1, r2;
	side_t       dv2_side;

	frl_div #(.NW(48), .DW(33), .QW(17), .TW($bits(side_t))) u_div_rs (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_s7),
		.num_i   ({dab_s7, 16'd0}),
		.den_i   (sab_s7),
		.tag_i   (side_s7),
		.valid_o (dv2_valid),
		.quo_o   (r1),
		.tag_o   (dv2_side)
	);

	frl_div #(.NW(48), .DW(33), .QW(17), .TW(1)) u_div_rp (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_s7),
		.num_i   ({dpq_s7, 16'd0}),
		.den_i   (spq_s7),
		.tag_i   (1'b0),
		.valid_o (),
		.quo_o   (r2),
		.tag_o   ()
	);

	// Stage 8: squares of the ratios.
	logic        valid_s8;
	logic [33:0] sq1_s8, sq2_s8;
	side_t       side_s8;

	always_ff @(posedge clk) begin
		sq1_s8  <= 34'(r1) * 34'(r1);
		sq2_s8  <= 34'(r2) * 34'(r2);
		side_s8 <= dv2_side;
	end

	// Stage 9: halve, round, saturate.
	logic [34:0] sum;
	logic [16:0] res;

	assign sum = 35'(sq1_s8) + 35'(sq2_s8) + 35'(1 << 17);
	assign res = sum[34:18];

	always_ff @(posedge clk) begin
		if (side_s8.zero_f) begin
			reflectance <= '0;
		end else if (side_s8.one_f || res > 17'(ONE_Q15)) begin
			reflectance <= ONE_Q15;
		end else begin
			reflectance <= res[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= sq_valid_s[16];
			valid_s7 <= valid_s6;
			valid_s8 <= dv2_valid;
			done     <= valid_s8;
		end
	end

	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("item did not produce a result at the pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##LATENCY !done)
		else $error("result without an item");

	a_equal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && index_incident == index_transmit) |-> ##LATENCY (reflectance == '0))
		else $error("equal indices did not give zero");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (reflectance <= ONE_Q15))
		else $error("reflectance above one");

endmodule

// ===== rtl/frl_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; a new item may enter in every cycle.
// ----------------------------------------------------------------------------
module frl_div #(
	parameter int NW = 62,
	parameter int DW = 32,
	parameter int QW = 31,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_i,
	input  logic [NW-1:0] num_i,
	input  logic [DW-1:0] den_i,
	input  logic [TW-1:0] tag_i,
	output logic          valid_o,
	output logic [QW-1:0] quo_o,
	output logic [TW-1:0] tag_o
);

	logic          valid_s [1:QW];
	logic [DW-1:0] rem_s   [1:QW];
	logic [QW-1:0] low_s   [1:QW];
	logic [QW-1:0] quo_s   [1:QW];
	logic [DW-1:0] den_s   [1:QW];
	logic [TW-1:0] tag_s   [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic          cur_valid;
		logic [DW-1:0] cur_rem;
		logic [QW-1:0] cur_low;
		logic [QW-1:0] cur_quo;
		logic [DW-1:0] cur_den;
		logic [TW-1:0] cur_tag;
		logic [DW:0]   shifted;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			// The high numerator bits stay below the divisor for every valid item.
			assign cur_valid = valid_i;
			assign cur_rem   = DW'(num_i[NW-1:QW]);
			assign cur_low   = num_i[QW-1:0];
			assign cur_quo   = '0;
			assign cur_den   = den_i;
			assign cur_tag   = tag_i;
		end else begin : g_next
			assign cur_valid = valid_s[k];
			assign cur_rem   = rem_s[k];
			assign cur_low   = low_s[k];
			assign cur_quo   = quo_s[k];
			assign cur_den   = den_s[k];
			assign cur_tag   = tag_s[k];
		end

		assign shifted = {cur_rem, cur_low[QW-1]};
		assign diff    = shifted - {1'b0, cur_den};
		assign ge      = !diff[DW];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			low_s[k+1] <= {cur_low[QW-2:0], 1'b0};
			quo_s[k+1] <= {cur_quo[QW-2:0], ge};
			den_s[k+1] <= cur_den;
			tag_s[k+1] <= cur_tag;
		end
	end

	assign valid_o = valid_s[QW];
	assign quo_o   = quo_s[QW];
	assign tag_o   = tag_s[QW];

endmodule

// ===== dv/fresnel_reflectance_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fresnel reflectance core testbench
// Drives cosine and index items through the core, predicts each reflectance
// in exact integer arithmetic unless a corner item gives a typed value, and
// compares every result in order. A short table of corner items comes first,
// then random items under several sender idle rates.
// ----------------------------------------------------------------------------
module fresnel_reflectance_core_tb;
	import frl_pkg::*;

	typedef struct {
		logic [15:0] c;
		logic [15:0] n1;
		logic [15:0] n2;
		bit          fixed;
		logic [15:0] refl;
	} corner_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] cos_incident;
	logic [15:0] index_incident;
	logic [15:0] index_transmit;
	logic        done;
	logic [15:0] reflectance;

	// Typed expectation that travels with the item currently on the inputs.
	bit          refl_fixed;
	logic [15:0] refl_typed;

	logic [15:0] refl_queue[$];
	int          accepted;
	int          failures;

	fresnel_reflectance_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cos_incident(cos_incident), .index_incident(index_incident),
		.index_transmit(index_transmit), .done(done), .reflectance(reflectance)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic longint unsigned amp_ratio(longint unsigned x, longint unsigned y);
		longint unsigned d;
		d = (x > y) ? x - y : y - x;
		return (d << 16) / (x + y);
	endfunction

	function automatic logic [15:0] fresnel_expect(logic [15:0] cin, logic [15:0] i1,
			logic [15:0] i2);
		longint unsigned c, n1, n2, om, n1sq, n2sq, lhs, rhs, ct, a, b, p, q;
		longint unsigned r1, r2, sum, res;
		c = 64'((cin > ONE_Q15) ? ONE_Q15 : cin);
		n1 = 64'(i1);
		n2 = 64'(i2);
		if (n1 == n2) return 16'd0;
		if (n2 == 0) return ONE_Q15;
		om = (64'd1 << 30) - c * c;
		n1sq = n1 * n1;
		n2sq = n2 * n2;
		lhs = n1sq * om;
		rhs = n2sq << 30;
		// Total internal reflection; sine squared of exactly one is not counted.
		if (lhs > rhs) return ONE_Q15;
		ct = isqrt((rhs - lhs) / n2sq);
		a = n1 * c;
		b = n2 * ct;
		p = n1 * ct;
		q = n2 * c;
		if (a + b == 0 || p + q == 0) return ONE_Q15;
		r1 = amp_ratio(a, b);
		r2 = amp_ratio(p, q);
		sum = r1 * r1 + r2 * r2;
		res = (sum + (64'd1 << 17)) >> 18;
		if (res > 64'(ONE_Q15)) res = 64'(ONE_Q15);
		return res[15:0];
	endfunction

	always @(posedge clk) begin
		logic [15:0] want;
		if (done) begin
			if (refl_queue.size() == 0) begin
				$error("reflectance: result %0d with no item outstanding", reflectance);
				failures++;
			end else begin
				want = refl_queue.pop_front();
				if (reflectance !== want) begin
					$error("reflectance: expected %0d, actual %0d", want, reflectance);
					failures++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			refl_queue.push_back(refl_fixed ? refl_typed
				: fresnel_expect(cos_incident, index_incident, index_transmit));
			accepted++;
		end
	end

	// Holds one item on the inputs from a falling edge until it is taken.
	task automatic send_item(logic [15:0] c, logic [15:0] n1, logic [15:0] n2,
			int idle_pct, bit fixed, logic [15:0] refl);
		int seen;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cos_incident <= c;
		index_incident <= n1;
		index_transmit <= n2;
		refl_fixed <= fixed;
		refl_typed <= refl;
		seen = accepted;
		do @(negedge clk); while (accepted == seen);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (refl_queue.size() != 0) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_index();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0) return 16'($urandom_range(65535));
		if (sel == 1) return 16'($urandom_range(8192, 8400));
		return 16'($urandom_range(8192, 65535));
	endfunction

	corner_t corners[] = '{
		'{16'd32768, 16'd8192,  16'd8192,  1, 16'd0},
		'{16'd65535, 16'd12000, 16'd12000, 1, 16'd0},
		'{16'd0,     16'd0,     16'd0,     1, 16'd0},
		'{16'd20000, 16'd8192,  16'd0,     1, ONE_Q15},
		'{16'd0,     16'd16384, 16'd8192,  1, ONE_Q15},
		'{16'd100,   16'd65535, 16'd8192,  1, ONE_Q15},
		'{16'd0,     16'd0,     16'd8192,  1, ONE_Q15},
		'{16'd0,     16'd8192,  16'd16384, 0, 16'd0},
		'{16'd32768, 16'd8192,  16'd12288, 0, 16'd0},
		'{16'd32768, 16'd12288, 16'd8192,  0, 16'd0},
		'{16'd65535, 16'd8192,  16'd65535, 0, 16'd0},
		'{16'd32769, 16'd65535, 16'd8192,  0, 16'd0},
		'{16'd28378, 16'd16384, 16'd8192,  0, 16'd0},
		'{16'd28377, 16'd16384, 16'd8192,  0, 16'd0},
		'{16'd1,     16'd8192,  16'd65535, 0, 16'd0},
		'{16'd16384, 16'd4096,  16'd8192,  0, 16'd0},
		'{16'd16384, 16'd8192,  16'd1,     0, 16'd0},
		'{16'd23170, 16'd10923, 16'd8192,  0, 16'd0},
		'{16'd32767, 16'd65534, 16'd65535, 0, 16'd0},
		'{16'd12345, 16'd0,     16'd9000,  0, 16'd0}
	};

	int idle_rate[4] = '{0, 81, 0, 24};

	initial begin
		logic [15:0] c, n1, n2;
		start = 1'b0;
		cos_incident = '0;
		index_incident = '0;
		index_transmit = '0;
		refl_fixed = 1'b0;
		refl_typed = '0;
		accepted = 0;
		failures = 0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (corners[i])
			send_item(corners[i].c, corners[i].n1, corners[i].n2, 0,
				corners[i].fixed, corners[i].refl);

		for (int ph = 0; ph < 4; ph++) begin
			for (int k = 0; k < 180; k++) begin
				c = ($urandom_range(9) == 0) ? 16'($urandom_range(32768, 65535))
					: 16'($urandom_range(32768));
				n1 = rand_index();
				n2 = ($urandom_range(19) == 0) ? n1 : rand_index();
				send_item(c, n1, n2, idle_rate[ph], 1'b0, 16'd0);
			end
			// Let the pipeline empty before the next rate.
			drain();
		end

		repeat (LATENCY + 10) @(negedge clk);
		if (failures == 0 && refl_queue.size() == 0)
			$display("** fresnel_reflectance_core: PASSED **");
		else
			$display("** fresnel_reflectance_core: FAILED **");
		$finish;
	end

	initial begin
		#2000000;
		$display("** fresnel_reflectance_core: FAILED **");
		$finish;
	end

endmodule
